// File: hdl/bmw_pkg.sv
// shared constants, payload and control types for the binary morphology window filter
`timescale 1ns / 1ps

package bmw_pkg;

    // frame and window limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_RADIUS = 2;

    // derived sizes
    localparam int WIN    = 2 * MAX_RADIUS + 1;
    localparam int RAM_W  = 2 * MAX_RADIUS;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int LW_W   = $clog2(MAX_WIDTH + 1);
    localparam int LH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int DLY_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int CIDX_W = $clog2(WIN);
    localparam int XS_W   = COL_W + 3;
    localparam int YS_W   = ROW_W + 3;

    // register port sizes
    localparam int DIM_W      = 11;
    localparam int CFG_RAD_W  = 2;
    localparam int CFG_DATA_W = 11;

    // register indexes
    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RADIUS = 2'd2,
        CFG_MODE   = 2'd3
    } t_cfg_idx;

    // input and output items
    typedef struct packed {
        logic [7:0] pixel_value;
        logic       flush;
    } t_in_item;

    typedef struct packed {
        logic pixel_white;
        logic frame_last;
    } t_out_item;

    // programmed registers
    typedef struct packed {
        logic [DIM_W-1:0]     width;
        logic [DIM_W-1:0]     height;
        logic [CFG_RAD_W-1:0] radius;
        logic                 mode;
    } t_cfg;

    // per-frame settings after saturation
    typedef struct packed {
        logic [LW_W-1:0]  w;
        logic [LH_W-1:0]  h;
        logic [RAD_W-1:0] r;
        logic             m;
    } t_lat;

    // what travels with one beat down the pipeline
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [COL_W-1:0] ox;
        logic [ROW_W-1:0] oy;
        t_lat             lat;
    } t_tok;

    // window controls shared by all column cells
    typedef struct packed {
        logic [COL_W-1:0] ox;
        logic [RAD_W-1:0] r;
        logic [LW_W-1:0]  w;
        logic             want;
        logic [WIN-1:0]   row_mask;
    } t_win;

endpackage

// File: hdl/bmw_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module bmw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read, read returns the old word on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bmw_cell.sv
// one window column cell: holds a vertical pixel column and tests it against the window
`timescale 1ns / 1ps

module bmw_cell import bmw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_shift,
    input  logic [WIN-1:0]    i_vec,
    input  logic [CIDX_W-1:0] i_idx,
    input  t_win              i_win,
    output logic [WIN-1:0]    o_vec,
    output logic              o_hit
);

    logic [WIN-1:0]  r_vec;
    logic [XS_W-1:0] x_base;
    logic [XS_W-1:0] x_idx;
    logic [XS_W-1:0] x_two_r;
    logic            col_ok;

    // column taken from the left neighbour on every beat
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_vec <= i_vec;
        end
    end

    // column position ox + r - idx must lie inside the window and the image
    always_comb begin
        x_base  = XS_W'(i_win.ox) + XS_W'(i_win.r);
        x_idx   = XS_W'(i_idx);
        x_two_r = XS_W'(i_win.r) << 1;
        col_ok  = (x_idx <= x_two_r) && (x_base >= x_idx) &&
                  ((x_base - x_idx) < XS_W'(i_win.w));
        o_hit   = col_ok && (|(~(r_vec ^ {WIN{i_win.want}}) & i_win.row_mask));
    end

    assign o_vec = r_vec;

endmodule

// File: hdl/bmw_seq.sv
// frame sequencer: raster counters, start-up delay and output position per beat
`timescale 1ns / 1ps

module bmw_seq import bmw_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_acc,
    input  t_in_item         i_item,
    input  t_cfg             i_cfg,
    output logic             o_beat,
    output t_tok             o_tok,
    output logic [COL_W-1:0] o_rd_col,
    output logic             o_pix
);

    logic             r_active;
    t_lat             r_lat;
    logic [DLY_W-1:0] r_delay;
    logic [DLY_W-1:0] r_lead;
    logic [COL_W-1:0] r_in_col;
    logic [LH_W-1:0]  r_in_row;
    logic [COL_W-1:0] r_out_col;
    logic [ROW_W-1:0] r_out_row;

    logic             start;
    logic             done_reg;
    t_lat             cfg_lat;
    t_lat             lat_cur;
    logic [DLY_W-1:0] delay_cur;
    logic [DLY_W-1:0] lead_cur;
    logic [COL_W-1:0] in_col_cur;
    logic [LH_W-1:0]  in_row_cur;
    logic [COL_W-1:0] out_col_cur;
    logic [ROW_W-1:0] out_row_cur;
    logic             done_cur;
    logic             emit;
    logic             last;
    logic             in_wrap;
    logic             out_wrap;

    // saturate the programmed registers into their legal ranges
    always_comb begin
        if (i_cfg.width == '0) begin
            cfg_lat.w = LW_W'(1);
        end else if (32'(i_cfg.width) > MAX_WIDTH) begin
            cfg_lat.w = LW_W'(MAX_WIDTH);
        end else begin
            cfg_lat.w = LW_W'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            cfg_lat.h = LH_W'(1);
        end else if (32'(i_cfg.height) > MAX_HEIGHT) begin
            cfg_lat.h = LH_W'(MAX_HEIGHT);
        end else begin
            cfg_lat.h = LH_W'(i_cfg.height);
        end
        if (32'(i_cfg.radius) > MAX_RADIUS) begin
            cfg_lat.r = RAD_W'(MAX_RADIUS);
        end else begin
            cfg_lat.r = RAD_W'(i_cfg.radius);
        end
        cfg_lat.m = i_cfg.mode;
    end

    // classify the transfer and work out this beat's positions
    always_comb begin
        done_reg    = r_in_row >= r_lat.h;
        start       = !r_active && !i_item.flush;
        o_beat      = i_acc && (r_active ? !(i_item.flush && !done_reg) : !i_item.flush);
        lat_cur     = start ? cfg_lat : r_lat;
        delay_cur   = start ? (DLY_W'(cfg_lat.r) * DLY_W'(cfg_lat.w) + DLY_W'(cfg_lat.r))
                            : r_delay;
        lead_cur    = start ? '0 : r_lead;
        in_col_cur  = start ? '0 : r_in_col;
        in_row_cur  = start ? '0 : r_in_row;
        out_col_cur = start ? '0 : r_out_col;
        out_row_cur = start ? '0 : r_out_row;
        done_cur    = in_row_cur >= lat_cur.h;
        emit        = lead_cur == delay_cur;
        in_wrap     = LW_W'(in_col_cur) == (lat_cur.w - LW_W'(1));
        out_wrap    = LW_W'(out_col_cur) == (lat_cur.w - LW_W'(1));
        last        = out_wrap && (LH_W'(out_row_cur) == (lat_cur.h - LH_W'(1)));

        o_tok.emit  = emit;
        o_tok.last  = last;
        o_tok.ox    = out_col_cur;
        o_tok.oy    = out_row_cur;
        o_tok.lat   = lat_cur;
        o_rd_col    = in_col_cur;
        o_pix       = |i_item.pixel_value;
    end

    // counters advance once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_lat     <= '{w: LW_W'(640), h: LH_W'(480), r: RAD_W'(1), m: 1'b0};
            r_delay   <= '0;
            r_lead    <= '0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (o_beat) begin
            r_lat   <= lat_cur;
            r_delay <= delay_cur;
            r_lead  <= emit ? lead_cur : lead_cur + DLY_W'(1);
            // input raster keeps running past the frame so the line store stays aligned
            if (in_wrap) begin
                r_in_col <= '0;
                r_in_row <= done_cur ? in_row_cur : in_row_cur + LH_W'(1);
            end else begin
                r_in_col <= in_col_cur + COL_W'(1);
                r_in_row <= in_row_cur;
            end
            if (emit) begin
                r_out_col <= out_wrap ? '0 : out_col_cur + COL_W'(1);
                r_out_row <= out_wrap ? out_row_cur + ROW_W'(1) : out_row_cur;
            end else begin
                r_out_col <= out_col_cur;
                r_out_row <= out_row_cur;
            end
            r_active <= !(emit && last);
        end
    end

`ifndef NO_ASSERTIONS
    // start-up count never runs past the frame delay
    a_lead_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_lead <= r_delay))
        else $error("start-up count beyond delay");

    // input row saturates at the frame height
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_in_row <= r_lat.h))
        else $error("input row beyond frame");

    // no output position beyond the frame while a frame is open
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (LH_W'(r_out_row) < r_lat.h))
        else $error("output row beyond frame");
`endif

endmodule

// File: hdl/binary_morphology_window_filter.sv
// top level of the binary morphology window filter: registers, line store and window chain
`timescale 1ns / 1ps

// Binary erosion / dilation over a square window of radius 0 to 2 on a raster pixel stream.
// One pixel is taken per clock, sustained, and one result leaves per clock once the window
// has filled; the rate is set by the single-column read and write of the line store each
// cycle and the one-column shift of the window cell chain. A frame opens with its first
// non-flush pixel, which latches width, height, radius and mode; later writes take effect on
// the next frame. Results trail their pixel by radius rows plus radius pixels of input
// transfers, and each passes the read, window and output registers after the transfer
// that completes its window; the last results are drained by flush beats (or by pixels
// sent after the frame, whose value is ignored), and the final result carries frame_last.
// The line store is one ram of MAX_WIDTH words of 2*MAX_RADIUS bits with no clearing pass
// after reset: rows that have not been written in the current frame are outside the image
// and masked. The whole pipeline holds while a finished result waits to be taken.
module binary_morphology_window_filter import bmw_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg             r_cfg;
    logic             adv;
    logic             acc;
    logic             beat;
    t_tok             tok;
    logic [COL_W-1:0] rd_col;
    logic             pix;
    logic [RAM_W-1:0] ram_rd;

    logic             r_b_valid;
    t_tok             r_b_tok;
    logic [COL_W-1:0] r_b_col;
    logic             r_b_pix;
    logic             r_b_byp;
    logic [RAM_W-1:0] r_b_byp_dat;
    logic [WIN-1:0]   b_vec;

    logic             r_c_valid;
    t_tok             r_c_tok;
    t_win             win;
    logic [YS_W-1:0]  y_base;
    logic [WIN-1:0]   cell_vec [WIN];
    logic [WIN-1:0]   hits;
    logic             any_hit;

    logic             r_out_valid;
    t_out_item        r_out;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{width: DIM_W'(640), height: DIM_W'(480),
                       radius: CFG_RAD_W'(1), mode: 1'b0};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data[DIM_W-1:0];
                CFG_RADIUS: r_cfg.radius <= i_cfg_data[CFG_RAD_W-1:0];
                CFG_MODE:   r_cfg.mode   <= i_cfg_data[0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    // pipeline moves whenever the output register is empty or its result is being taken
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;
    assign acc     = i_valid && adv;

    bmw_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_item   (i_in),
        .i_cfg    (r_cfg),
        .o_beat   (beat),
        .o_tok    (tok),
        .o_rd_col (rd_col),
        .o_pix    (pix)
    );

    // line store: column of the older rows, shifted down one row on each write
    bmw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (adv && r_b_valid),
        .i_waddr (r_b_col),
        .i_wdata (b_vec[RAM_W-1:0]),
        .i_re    (adv),
        .i_raddr (rd_col),
        .o_rdata (ram_rd)
    );

    // column vector of the beat in the read stage, with forwarding of a same-column write
    assign b_vec = {(r_b_byp ? r_b_byp_dat : ram_rd), r_b_pix};

    // read stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_tok     <= tok;
            r_b_col     <= rd_col;
            r_b_pix     <= pix;
            r_b_byp     <= r_b_valid && (r_b_col == rd_col);
            r_b_byp_dat <= b_vec[RAM_W-1:0];
        end
    end

    // window stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid && r_b_tok.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_tok <= r_b_tok;
        end
    end

    // window controls: rows oy + r - i inside the window and the image
    always_comb begin
        win.ox   = r_c_tok.ox;
        win.r    = r_c_tok.lat.r;
        win.w    = r_c_tok.lat.w;
        win.want = r_c_tok.lat.m;
        y_base   = YS_W'(r_c_tok.oy) + YS_W'(r_c_tok.lat.r);
        for (int i = 0; i < WIN; i++) begin
            win.row_mask[i] = (YS_W'(i) <= (YS_W'(r_c_tok.lat.r) << 1)) &&
                              (y_base >= YS_W'(i)) &&
                              ((y_base - YS_W'(i)) < YS_W'(r_c_tok.lat.h));
        end
    end

    // chain of column cells, newest column in cell zero
    for (genvar j = 0; j < WIN; j++) begin : g_cell
        bmw_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (adv && r_b_valid),
            .i_vec   ((j == 0) ? b_vec : cell_vec[(j == 0) ? 0 : j - 1]),
            .i_idx   (CIDX_W'(j)),
            .i_win   (win),
            .o_vec   (cell_vec[j]),
            .o_hit   (hits[j])
        );
    end

    assign any_hit = |hits;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.pixel_white <= r_c_tok.lat.m ? any_hit : !any_hit;
            r_out.frame_last  <= r_c_tok.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

`ifndef NO_ASSERTIONS
    // a result in the window stage always has its centre inside the frame
    a_centre_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> ((LW_W'(r_c_tok.ox) < r_c_tok.lat.w) &&
                       (LH_W'(r_c_tok.oy) < r_c_tok.lat.h)))
        else $error("window centre outside frame");

    // pipeline stages hold while the output waits
    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_b_valid) && $stable(r_c_valid)))
        else $error("pipeline moved while held");

    // a waiting result stays put until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("waiting result changed");
`endif

endmodule
